### design/dtq_pkg.sv
package dtq_pkg;
  localparam int Depth = 64;
  localparam int IdxW = 6;
  localparam int CntW = 7;
  localparam int ByteW = 22;

  typedef enum logic [2:0] {
    CMD_ENQ = 3'd0, CMD_DEQ = 3'd1, CMD_PEEK = 3'd2, CMD_PURGE_MAC = 3'd3,
    CMD_PURGE_IP = 3'd4, CMD_REM_MAC = 3'd5, CMD_REM_IP = 3'd6, CMD_NONE = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {S_IDLE, S_MARK, S_CLOSE, S_OUT} state_t;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic CFG_PKT_LIMIT = 1'b0;
  localparam logic CFG_BYTE_LIMIT = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] bytes;
    logic [47:0] mac;
    logic [31:0] ip;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic   shift;   // close up: take neighbor's entry when this or a lower slot is flagged
    logic   load;    // write tail entry
    logic   by_mac;
    logic   mark;    // latch match flags
    logic   first;   // keep only the first match
    logic   head;    // mark the head slot instead of comparing keys
    logic [IdxW:0] tail;
    entry_t key;
  } cell_ctl_t;
endpackage

### design/dtq_cell.sv
// One slot of the queue: holds an entry and a removal flag.
module dtq_cell (
  input  logic             clk,
  input  logic             rst,
  input  dtq_pkg::cell_ctl_t ctl,
  input  logic [dtq_pkg::IdxW-1:0] my_idx,
  input  logic             kill_in,   // a slot at or below this one is removed
  input  logic             prev_hit,  // a lower slot already matched
  input  dtq_pkg::entry_t  up_entry,
  input  logic             up_rm,     // removal flag of the upper neighbor
  output dtq_pkg::entry_t  entry,
  output logic             hit,
  output logic             kill,
  output logic             rm
);
  import dtq_pkg::*;
  logic in_use;
  logic key_eq;
  logic match;

  // compare against the key, or pick the head slot
  assign in_use = ({1'b0, my_idx} < ctl.tail);
  assign key_eq = ctl.by_mac ? (entry.mac == ctl.key.mac) : (entry.ip == ctl.key.ip);
  assign match = in_use && (ctl.head ? (my_idx == '0) : key_eq);
  assign hit = match | prev_hit;
  assign kill = kill_in | rm;

  // removal flag, moves along with the entry while closing up
  always_ff @(posedge clk) begin
    if (rst) rm <= 1'b0;
    else if (ctl.mark) rm <= match && !(ctl.first && prev_hit);
    else if (ctl.shift && kill_in) rm <= up_rm;
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (ctl.load && ({1'b0, my_idx} == ctl.tail)) entry <= ctl.key;
    else if (ctl.shift && kill_in) entry <= up_entry;
  end
endmodule

### design/dtq_chain.sv
// Row of cells; entries close up toward the head one step per shift cycle.
module dtq_chain (
  input  logic             clk,
  input  logic             rst,
  input  dtq_pkg::cell_ctl_t ctl,
  output dtq_pkg::entry_t  ents [dtq_pkg::Depth],
  output logic [dtq_pkg::Depth-1:0] rmv,
  output logic             any_hit
);
  import dtq_pkg::*;
  logic [Depth:0] hit_c;
  logic [Depth:0] kill_c;
  entry_t nb [Depth];
  logic [Depth-1:0] rm_up;
  assign hit_c[0] = 1'b0;
  assign kill_c[0] = 1'b0;
  assign any_hit = hit_c[Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    if (g == Depth - 1) begin : g_end
      assign nb[g] = ents[g];
      assign rm_up[g] = 1'b0;
    end else begin : g_mid
      assign nb[g] = ents[g+1];
      assign rm_up[g] = rmv[g+1];
    end
    dtq_cell u_cell (
      .clk, .rst, .ctl, .my_idx(IdxW'(g)),
      .kill_in(kill_c[g] | rmv[g]), .prev_hit(hit_c[g]),
      .up_entry(nb[g]), .up_rm(rm_up[g]), .entry(ents[g]), .hit(hit_c[g+1]),
      .kill(kill_c[g+1]), .rm(rmv[g])
    );
  end
endmodule

### design/drop_tail_queue_with_purge_top.sv
// Drop-tail packet queue of 64 entries held in a chain of cells, limited by
// packet count or by queued bytes, with dequeue, peek, purge and remove-first
// by destination MAC or IP. One word is handled at a time: s_tready stays low
// from the accepting edge until the result word has been taken. Enqueue, peek
// and unused codes pass through the mark state, where the result fields are
// registered, and the output state, which raises m_tvalid. Dequeue, purge and
// remove-first mark the cells to go in parallel, then close the chain one gap
// per cycle until no marked cell is left, then pass through the output state.
// The next word is taken in the cycle after the result word is accepted.
// Configuration is meant to be written only while no word is in flight.
module drop_tail_queue_with_purge_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: cmd[2:0], packet_id[18:3], packet_bytes[34:19], dest_mac[82:35],
  //        dest_ip[114:83], position[120:115], zero fill to 128
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: status[1:0], out_id[17:2], out_bytes[33:18], removed_count[40:34],
  //        queued_packets[47:41], queued_bytes[69:48], zero fill to 72
  output logic [71:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [21:0]  cfg_data
);
  import dtq_pkg::*;

  state_t st, st_next;

  logic [6:0] pkt_limit;
  logic [21:0] byte_limit;
  logic [CntW-1:0] cnt;
  logic [ByteW-1:0] btot;
  logic [2:0] cmd;
  entry_t key;
  logic [IdxW-1:0] pos;
  logic [1:0] status;
  logic [15:0] oid, obytes;
  logic [CntW-1:0] removed;
  cell_ctl_t ctl;
  entry_t ents [Depth];
  logic [Depth-1:0] rmv;
  logic any_hit;
  logic [22:0] sum;
  logic full;
  logic take;
  logic is_purge;
  logic is_rem;
  logic [1:0] mk_status;
  logic [15:0] mk_id, mk_bytes;
  logic [Depth-1:0] low;
  logic [15:0] low_b;
  logic [15:0] low_id;

  assign cfg_ready = 1'b1;
  assign s_tready = (st == S_IDLE) && !m_tvalid;
  assign take = s_tvalid && s_tready;
  assign is_purge = (cmd == CMD_PURGE_MAC) || (cmd == CMD_PURGE_IP);
  assign is_rem = (cmd == CMD_REM_MAC) || (cmd == CMD_REM_IP);

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_limit <= '0;
      byte_limit <= 22'd65536;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PKT_LIMIT) pkt_limit <= cfg_data[6:0];
      else byte_limit <= cfg_data;
    end
  end

  dtq_chain u_chain (.clk, .rst, .ctl, .ents, .rmv, .any_hit);

  assign sum = {1'b0, btot} + {7'd0, key.bytes};
  always_comb begin
    if (pkt_limit != 0)
      full = (cnt >= ((pkt_limit < 7'(Depth)) ? pkt_limit : 7'(Depth)));
    else
      full = (sum > {1'b0, byte_limit}) || (cnt >= 7'(Depth));
    if (sum[22]) full = 1'b1;
  end

  // chain controls
  always_comb begin
    ctl = '0;
    ctl.tail = cnt;
    ctl.key = key;
    ctl.by_mac = (cmd == CMD_PURGE_MAC) || (cmd == CMD_REM_MAC);
    ctl.first = (cmd == CMD_REM_MAC) || (cmd == CMD_REM_IP);
    ctl.head = (cmd == CMD_DEQ);
    ctl.mark = (st == S_MARK);
    ctl.shift = (st == S_CLOSE);
    ctl.load = (st == S_MARK) && (cmd == CMD_ENQ) && !full;
  end

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE: if (take) st_next = S_MARK;
      S_MARK: st_next = (cmd == CMD_DEQ || (cmd >= CMD_PURGE_MAC && cmd <= CMD_REM_IP))
                        ? S_CLOSE : S_OUT;
      S_CLOSE: if (rmv == '0) st_next = S_OUT;
      S_OUT: st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= S_IDLE;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= s_tdata[2:0];
      key.id <= s_tdata[18:3];
      key.bytes <= s_tdata[34:19];
      key.mac <= s_tdata[82:35];
      key.ip <= s_tdata[114:83];
      pos <= s_tdata[120:115];
    end
  end

  // result fields decided in the mark cycle
  always_comb begin
    mk_status = ST_DONE;
    mk_id = '0;
    mk_bytes = '0;
    case (cmd) inside
      CMD_ENQ: if (full) mk_status = ST_FULL;
      CMD_DEQ: begin
        if (cnt == '0) mk_status = ST_EMPTY;
        else begin
          mk_id = ents[0].id;
          mk_bytes = ents[0].bytes;
        end
      end
      CMD_PEEK: begin
        if ({1'b0, pos} < cnt) begin
          mk_id = ents[pos].id;
          mk_bytes = ents[pos].bytes;
        end else mk_status = ST_EMPTY;
      end
      CMD_REM_MAC, CMD_REM_IP: if (!any_hit) mk_status = ST_EMPTY;
      CMD_PURGE_MAC, CMD_PURGE_IP: mk_status = ST_DONE;
      default: mk_status = ST_EMPTY;
    endcase
  end

  // lowest marked slot, one per close cycle
  always_comb begin
    low = rmv & (~rmv + 1'b1);
    low_b = '0;
    low_id = '0;
    for (int i = 0; i < Depth; i++) begin
      if (low[i]) begin
        low_b = ents[i].bytes;
        low_id = ents[i].id;
      end
    end
  end

  // totals and results
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      btot <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (st == S_OUT) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (st == S_MARK) begin
        status <= mk_status;
        oid <= mk_id;
        obytes <= mk_bytes;
        removed <= '0;
        if (cmd == CMD_ENQ && !full) begin
          cnt <= cnt + 1'b1;
          btot <= sum[ByteW-1:0];
        end
        if (cmd == CMD_DEQ && cnt != '0) begin
          btot <= btot - ByteW'(ents[0].bytes);
          cnt <= cnt - 1'b1;
        end
      end
      // each close cycle the lowest marked cell leaves
      if (st == S_CLOSE && rmv != '0 && cmd != CMD_DEQ) begin
        cnt <= cnt - 1'b1;
        btot <= btot - ByteW'(low_b);
        if (is_purge) removed <= removed + 1'b1;
        if (is_rem) begin
          oid <= low_id;
          obytes <= low_b;
        end
      end
    end
  end

  assign m_tdata = {2'd0, btot, cnt, removed, obytes, oid, status};
endmodule

### design/dtq_checker.sv
module dtq_props (
  input logic clk, input logic rst,
  input logic s_tvalid, input logic s_tready,
  input logic m_tvalid, input logic m_tready,
  input logic [71:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("out hold");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("accept while result pending");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[47:41] <= 7'd64) else $error("count range");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3) else $error("status code");
endmodule

bind drop_tail_queue_with_purge_top dtq_props u_props (.*);
